[rtl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned NUM_ENT  = 9;
  localparam int unsigned ENT_W    = 16;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned DET_W    = 50;
  localparam int unsigned LO_W     = 8;
  localparam int unsigned QBITS    = 32;
  localparam int unsigned IN_DW    = 144;
  localparam int unsigned OUT_DW   = 344;

  // State carried through one restoring division step (nine lanes share |det|)
  typedef struct packed {
    logic [NUM_ENT-1:0][ENT_W-1:0] m;     // input entries, for the echo case
    logic [NUM_ENT-1:0][DET_W-1:0] rem;   // partial remainders
    logic [NUM_ENT-1:0][LO_W-1:0]  lo;    // dividend bits still to shift in
    logic [NUM_ENT-1:0][QBITS-1:0] q;     // quotient magnitudes
    logic [NUM_ENT-1:0]            ovf;   // quotient magnitude >= 2^32
    logic [NUM_ENT-1:0]            neg;   // quotient is negative
    logic [DET_W-1:0]              dabs;  // |det|
    logic [DET_W-1:0]              det;   // signed determinant
    logic                          zero;  // det == 0
  } div_t;

  typedef struct packed {
    logic [NUM_ENT-1:0][RES_W-1:0] r;
    logic [DET_W-1:0]              det;
    logic                          singular;
  } res_t;

endpackage

[rtl/mi3_front.sv]
// ----------------------------------------------------------------------------
// mi3_front
// Cofactor products, adjugate, determinant and divider setup in five stages.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [mi3_pkg::IN_DW-1:0]      in_data,
  output logic                           out_vld,
  output mi3_pkg::div_t                  out_div
);

  logic signed [15:0] m_in [9];

  // stage 1: 2x2 products
  logic              s1_vld_r;
  logic [8:0][15:0]  s1_m_r;
  logic signed [31:0] s1_pa_r [9];
  logic signed [31:0] s1_pb_r [9];
  logic signed [31:0] pa_nxt [9];
  logic signed [31:0] pb_nxt [9];

  // stage 2: adjugate
  logic              s2_vld_r;
  logic [8:0][15:0]  s2_m_r;
  logic signed [32:0] s2_adj_r [9];

  // stage 3: row-one expansion products
  logic              s3_vld_r;
  logic [8:0][15:0]  s3_m_r;
  logic signed [32:0] s3_adj_r [9];
  logic signed [48:0] s3_dp_r [3];

  // stage 4: determinant
  logic              s4_vld_r;
  logic [8:0][15:0]  s4_m_r;
  logic signed [32:0] s4_adj_r [9];
  logic signed [49:0] s4_det_r;

  // stage 5: divider setup
  logic              s5_vld_r;
  mi3_pkg::div_t     s5_div_r;
  mi3_pkg::div_t     div_nxt;
  logic [49:0]       dabs;
  logic [31:0]       adj_abs;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m_in[i] = $signed(in_data[i*16 +: 16]);
    end
    pa_nxt[0] = m_in[4] * m_in[8];  pb_nxt[0] = m_in[5] * m_in[7];
    pa_nxt[1] = m_in[2] * m_in[7];  pb_nxt[1] = m_in[1] * m_in[8];
    pa_nxt[2] = m_in[1] * m_in[5];  pb_nxt[2] = m_in[2] * m_in[4];
    pa_nxt[3] = m_in[5] * m_in[6];  pb_nxt[3] = m_in[3] * m_in[8];
    pa_nxt[4] = m_in[0] * m_in[8];  pb_nxt[4] = m_in[2] * m_in[6];
    pa_nxt[5] = m_in[2] * m_in[3];  pb_nxt[5] = m_in[0] * m_in[5];
    pa_nxt[6] = m_in[3] * m_in[7];  pb_nxt[6] = m_in[4] * m_in[6];
    pa_nxt[7] = m_in[1] * m_in[6];  pb_nxt[7] = m_in[0] * m_in[7];
    pa_nxt[8] = m_in[0] * m_in[4];  pb_nxt[8] = m_in[1] * m_in[3];
  end

  always_comb begin
    dabs = s4_det_r[49] ? 50'(-s4_det_r) : 50'(s4_det_r);
    div_nxt      = '0;
    div_nxt.m    = s4_m_r;
    div_nxt.dabs = dabs;
    div_nxt.det  = s4_det_r;
    div_nxt.zero = (s4_det_r == '0);
    adj_abs      = '0;
    for (int i = 0; i < 9; i++) begin
      adj_abs = s4_adj_r[i][32] ? 32'(-s4_adj_r[i]) : 32'(s4_adj_r[i]);
      // top 24 dividend bits go straight into the remainder
      div_nxt.rem[i] = {26'd0, adj_abs[31:8]};
      div_nxt.lo[i]  = adj_abs[7:0];
      div_nxt.ovf[i] = ({26'd0, adj_abs[31:8]} >= dabs);
      div_nxt.neg[i] = s4_adj_r[i][32] ^ s4_det_r[49];
      div_nxt.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r <= in_data;
      s2_m_r <= s1_m_r;
      s3_m_r <= s2_m_r;
      s4_m_r <= s3_m_r;
      for (int i = 0; i < 9; i++) begin
        s1_pa_r[i]  <= pa_nxt[i];
        s1_pb_r[i]  <= pb_nxt[i];
        s2_adj_r[i] <= 33'(s1_pa_r[i]) - 33'(s1_pb_r[i]);
        s3_adj_r[i] <= s2_adj_r[i];
        s4_adj_r[i] <= s3_adj_r[i];
      end
      s3_dp_r[0] <= $signed(s2_m_r[0]) * s2_adj_r[0];
      s3_dp_r[1] <= $signed(s2_m_r[1]) * s2_adj_r[3];
      s3_dp_r[2] <= $signed(s2_m_r[2]) * s2_adj_r[6];
      s4_det_r   <= 50'(s3_dp_r[0]) + 50'(s3_dp_r[1]) + 50'(s3_dp_r[2]);
      s5_div_r   <= div_nxt;
    end
  end

  assign out_vld = s5_vld_r;
  assign out_div = s5_div_r;

endmodule

[rtl/mi3_div_step.sv]
// ----------------------------------------------------------------------------
// mi3_div_step
// One registered restoring division step for all nine quotient lanes.
// ----------------------------------------------------------------------------
module mi3_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  mi3_pkg::div_t in_div,
  output logic          out_vld,
  output mi3_pkg::div_t out_div
);

  logic          vld_r;
  mi3_pkg::div_t div_r;
  mi3_pkg::div_t div_nxt;
  logic [50:0]   trial;

  always_comb begin
    div_nxt = in_div;
    trial   = '0;
    for (int i = 0; i < 9; i++) begin
      trial         = {in_div.rem[i], in_div.lo[i][7]};
      div_nxt.lo[i] = {in_div.lo[i][6:0], 1'b0};
      if (trial >= {1'b0, in_div.dabs}) begin
        div_nxt.rem[i] = 50'(trial - {1'b0, in_div.dabs});
        div_nxt.q[i]   = {in_div.q[i][30:0], 1'b1};
      end else begin
        div_nxt.rem[i] = trial[49:0];
        div_nxt.q[i]   = {in_div.q[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_div = div_r;

endmodule

[rtl/matrix3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse
// Pipelined 3x3 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per matrix, nine signed Q8.8 entries in in_tdata.
//   out_* : one item per matrix: nine signed Q16.16 inverse entries and the
//           exact Q26.24 determinant in out_tdata, the singular flag in
//           out_tuser. A singular matrix returns its own entries in Q16.16.
//   Pipeline: 5 setup stages, 32 quotient-bit stages, 1 saturation stage
//           and the output register.
//   Throughput: one matrix per cycle while the pipeline is not stalled;
//           each of the 32 divider stages resolves one quotient bit for
//           all nine entries, so nothing iterates.
//   Stall: the whole pipeline freezes while the skid register is full; the
//           output register and the skid register let one more item arrive
//           after out_tready drops, so in_tready is a register output.
//   Reset: clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module matrix3_inverse (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // a11, a12, a13, a21, a22, a23, a31, a32, a33 (16 bits each)
  input  logic [mi3_pkg::IN_DW-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33 (32 bits each), det (50), pad
  output logic [mi3_pkg::OUT_DW-1:0]     out_tdata,
  // singular
  output logic                           out_tuser
);

  localparam int unsigned NSTEP = mi3_pkg::QBITS;

  logic          en;
  logic          vld [NSTEP+1];
  mi3_pkg::div_t dv  [NSTEP+1];

  logic          tail_vld_r;
  mi3_pkg::res_t tail_r;
  mi3_pkg::res_t tail_nxt;

  logic          out_vld_r;
  mi3_pkg::res_t out_r;
  logic          skid_vld_r;
  mi3_pkg::res_t skid_r;
  logic          out_take;

  // Advance the whole pipe unless the skid register holds an item
  assign en        = !skid_vld_r;
  assign in_tready = en;

  mi3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_data (in_tdata),
    .out_vld (vld[0]),
    .out_div (dv[0])
  );

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    mi3_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (vld[k]),
      .in_div  (dv[k]),
      .out_vld (vld[k+1]),
      .out_div (dv[k+1])
    );
  end

  // Sign, saturate, and pick the echo for a singular matrix
  always_comb begin
    tail_nxt          = '0;
    tail_nxt.singular = dv[NSTEP].zero;
    tail_nxt.det      = dv[NSTEP].det;
    for (int i = 0; i < 9; i++) begin
      if (dv[NSTEP].zero) begin
        tail_nxt.r[i] = {{8{dv[NSTEP].m[i][15]}}, dv[NSTEP].m[i], 8'd0};
      end else if (!dv[NSTEP].neg[i]) begin
        if (dv[NSTEP].ovf[i] || dv[NSTEP].q[i][31]) begin
          tail_nxt.r[i] = 32'h7FFF_FFFF;
        end else begin
          tail_nxt.r[i] = dv[NSTEP].q[i];
        end
      end else begin
        if (dv[NSTEP].ovf[i] || (dv[NSTEP].q[i] > 32'h8000_0000)) begin
          tail_nxt.r[i] = 32'h8000_0000;
        end else begin
          tail_nxt.r[i] = 32'(-dv[NSTEP].q[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_vld_r <= 1'b0;
    end else if (en) begin
      tail_vld_r <= vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r <= tail_nxt;
    end
  end

  assign out_take = out_vld_r && out_tready;

  // Output register plus skid: the tail goes to the output when it is free,
  // otherwise it parks in the skid register and the pipe holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (tail_vld_r) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (tail_vld_r) begin
      if (!out_vld_r || out_take) begin
        out_r <= tail_r;
      end else begin
        skid_r <= tail_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_r.det, out_r.r};
  assign out_tuser  = out_r.singular;

  // The skid register only fills behind a held output item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds an item while the output register is empty");

  // A stalled output with a full skid keeps the skid item for the next cycle
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_tready) |=> (skid_vld_r && $stable(skid_r)))
    else $error("skid item lost under stall");

  // The singular flag and a zero determinant always go together
  a_singular_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[337:288] == 50'd0)))
    else $error("singular flag disagrees with determinant");

endmodule

[verif/matrix3_inverse_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3_inverse_tb
// Streams 3x3 Q8.8 matrices through the inverse pipeline and checks every
// returned inverse, determinant and singular flag against a local predictor,
// with random idle cycles on both the input and output sides.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;

  localparam int NUM_RANDOM = 1200;
  localparam int WDOG_LIMIT = 5000;

  typedef logic signed [15:0] q8_t;
  typedef q8_t mat_t [9];

  typedef struct {
    logic [31:0] r [9];
    logic [49:0] det;
    logic        singular;
  } inv_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [mi3_pkg::IN_DW-1:0] in_tdata = '0;   // a11 .. a33, 16 bits each
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mi3_pkg::OUT_DW-1:0] out_tdata;      // r11 .. r33 (32 each), det (50), pad
  logic out_tuser;                            // singular

  logic [mi3_pkg::IN_DW-1:0] pending_q [$];
  inv_t expected_q [$];
  int send_idle_pct = 38;
  int recv_idle_pct = 46;
  bit stim_done = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  matrix3_inverse dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adjugate over determinant, exact in 64 bits; singular echoes the input.
  function automatic inv_t invert(logic [mi3_pkg::IN_DW-1:0] bits);
    longint m [9];
    longint adj [9];
    longint d, num, quo;
    inv_t res;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(bits[16*i +: 16]));
    adj[0] = m[4]*m[8] - m[5]*m[7];
    adj[1] = -(m[1]*m[8] - m[2]*m[7]);
    adj[2] = m[1]*m[5] - m[2]*m[4];
    adj[3] = -(m[3]*m[8] - m[5]*m[6]);
    adj[4] = m[0]*m[8] - m[2]*m[6];
    adj[5] = -(m[0]*m[5] - m[2]*m[3]);
    adj[6] = m[3]*m[7] - m[4]*m[6];
    adj[7] = -(m[0]*m[7] - m[1]*m[6]);
    adj[8] = m[0]*m[4] - m[1]*m[3];
    d = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
    res.det = d[49:0];
    res.singular = (d == 0);
    for (int i = 0; i < 9; i++) begin
      if (d == 0) begin
        num = m[i] * 256;
        res.r[i] = num[31:0];
      end else begin
        num = adj[i] * 64'sd16777216;
        quo = num / d;   // truncates toward zero
        if (quo > 64'sd2147483647) quo = 64'sd2147483647;
        if (quo < -64'sd2147483648) quo = -64'sd2147483648;
        res.r[i] = quo[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [mi3_pkg::IN_DW-1:0] pack(mat_t a);
    logic [mi3_pkg::IN_DW-1:0] v;
    for (int i = 0; i < 9; i++) v[16*i +: 16] = a[i];
    return v;
  endfunction

  // Driver: advance to the next item once the current one is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) expected_q.push_back(invert(in_tdata));
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= pending_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each delivered item with the oldest prediction.
  always @(posedge clk) begin
    inv_t exp_res;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (out_tdata[32*i +: 32] !== exp_res.r[i]) begin
              $error("r%0d%0d: expected %0d, got %0d", i/3 + 1, i%3 + 1,
                     $signed(exp_res.r[i]), $signed(out_tdata[32*i +: 32]));
              errors++;
            end
          if (out_tdata[288 +: 50] !== exp_res.det) begin
            $error("det: expected %0d, got %0d", $signed(exp_res.det),
                   $signed(out_tdata[288 +: 50]));
            errors++;
          end
          if (out_tuser !== exp_res.singular) begin
            $error("singular: expected %0b, got %0b", exp_res.singular, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: drop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else if (!stim_done || expected_q.size() > 0) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("** matrix3_inverse: FAILED **");
        $finish;
      end
    end
  end

  function automatic q8_t rand_entry(int mode);
    case (mode)
      0: return q8_t'($urandom());
      1: return q8_t'($urandom_range(0, 1024)) - 16'sd512;
      2: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      default: return q8_t'($urandom_range(0, 8)) - 16'sd4;
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t a;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 9; i++) a[i] = rand_entry(mode);
    // Force a singular case now and then: copy or zero a row.
    case ($urandom_range(9))
      0: for (int c = 0; c < 3; c++) a[3 + c] = a[c];
      1: for (int c = 0; c < 3; c++) a[6 + c] = 16'sd0;
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_phase(int count);
    for (int k = 0; k < count; k++) pending_q.push_back(pack(rand_matrix()));
    while (pending_q.size() > 0 || in_tvalid) @(posedge clk);
  endtask

  initial begin
    mat_t a;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, scaled identity, zero, extremes, small det, echo case.
    a = '{16'sd256, 0, 0, 0, 16'sd256, 0, 0, 0, 16'sd256};
    pending_q.push_back(pack(a));
    a = '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};            // scaled identity, inverse entries 256.0
    pending_q.push_back(pack(a));
    a = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
    pending_q.push_back(pack(a));
    a = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
    pending_q.push_back(pack(a));
    a = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
          16'sh7FFF, 16'sh8000, 16'sh8000};
    pending_q.push_back(pack(a));
    a = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh7FFF};                     // large det
    pending_q.push_back(pack(a));
    a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    pending_q.push_back(pack(a));
    a = '{16'sh7FFF, 16'sh8000, -16'sd1, 16'sh7FFF, 16'sh8000, -16'sd1,
          16'sd3, 16'sd5, 16'sd7};                              // singular echo
    pending_q.push_back(pack(a));
    a = '{16'sd2, 16'sd3, 16'sd5, 16'sd7, 16'sd11, 16'sd13, 16'sd17, 16'sd19, 16'sd23};
    pending_q.push_back(pack(a));
    a = '{-16'sd256, 16'sd512, 0, 16'sd128, -16'sd1, 16'sd64, 0, 16'sd3, -16'sd700};
    pending_q.push_back(pack(a));
    a = '{0, 16'sd256, 0, 0, 0, 16'sd256, 16'sd256, 0, 0};     // permutation
    pending_q.push_back(pack(a));
    a = '{-16'sd1, 0, 0, 0, -16'sd1, 0, 0, 0, 16'sh7FFF};      // negative diagonal entries
    pending_q.push_back(pack(a));
    send_phase(0);

    send_phase(NUM_RANDOM / 3);
    send_idle_pct = 46;
    recv_idle_pct = 38;
    send_phase(NUM_RANDOM / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_phase(NUM_RANDOM - 2 * (NUM_RANDOM / 3));
    stim_done = 1'b1;

    while (expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("** matrix3_inverse: PASSED **");
    end else begin
      $display("** matrix3_inverse: FAILED **");
    end
    $finish;
  end
endmodule
